// File: src/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the term sorter
// Sizes, the term and queue record layouts, and the back-end state encoding.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int MAX_TERMS = 32;
	localparam int COEF_W    = 64;
	localparam int DEG_W     = 16;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int TERM_W    = COEF_W + DEG_W;
	localparam int TDATA_W   = ((TERM_W + 7) / 8) * 8;

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TERMS);

	// Coefficient sits in the low bits so the struct matches tdata packing.
	typedef struct packed {
		logic [DEG_W-1:0]  deg;
		logic [COEF_W-1:0] coef;
	} term_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		term_t            term;
		logic             store;  // term goes into the store
		logic             last;   // final term of the polynomial
		logic             drop;   // some term of this run was dropped
		logic [CNT_W-1:0] cnt;    // stored terms so far, this one included if stored
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_RD_I,
		ST_LD_I,
		ST_CMP,
		ST_WB,
		ST_ERD,
		ST_EOUT
	} back_state_t;

endpackage
`default_nettype wire

// File: src/term_sort_by_degree.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// term_sort_by_degree: polynomial term sorter by ascending degree
// Collects terms, sorts each finished polynomial by degree, streams it out.
// ----------------------------------------------------------------------------
// Terms arrive on the slave stream, one item per term: tdata carries the
// 64-bit coefficient pattern and the 16-bit degree, and tlast marks the last
// term of a polynomial. Up to MAX_TERMS terms are kept per polynomial; later
// ones are dropped, and then every result of that polynomial has tuser set.
// Results leave on the master stream in ascending degree, with tlast on the
// final term. Ties come out in the order the interchange sort leaves them.
// Items are accepted whenever the record queue has room; this small queue in front of the store
// lets terms be accepted while the back end is still sorting or emitting.
// After the last term of a polynomial reaches the back end, the sort runs
// through the single read and write port of the term store, and is skipped
// for a single term; each result is then read from the store and loaded
// into the output register.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the front keeps accepting until the queue fills.
// Reset clears the run counter, the drop flag, the queue and the output
// valid; the term store needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module term_sort_by_degree (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [tsd_pkg::TDATA_W-1:0] s_tdata,  // coefficient_bits, degree
	input  wire logic                        s_tlast,  // is_last
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [tsd_pkg::TDATA_W-1:0] m_tdata,  // sorted_coefficient, sorted_degree
	output logic                             m_tlast,  // end_of_run
	output logic                             m_tuser   // overflowed
);

	tsd_pkg::q_stat_t q_stat;
	tsd_pkg::rec_t    push_rec;
	tsd_pkg::rec_t    pop_rec;
	logic             push;
	logic             pop;

	// The front end classifies each term as stored or dropped.
	tsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	// The queue decouples input acceptance from the sort.
	tsd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.q_stat   (q_stat)
	);

	// The back end owns the store, runs the sort and drives the results.
	tsd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_rec  (pop_rec),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// File: src/tsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/tsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_front: input acceptance and classification
// Counts the terms of the current run, marks terms beyond capacity as
// dropped and pushes one record per item into the queue.
// ----------------------------------------------------------------------------
module tsd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [tsd_pkg::TDATA_W-1:0] s_tdata,
	input  wire logic                        s_tlast,
	input  wire tsd_pkg::q_stat_t            q_stat,
	output logic                             push,
	output tsd_pkg::rec_t                    push_rec
);

	logic [tsd_pkg::CNT_W-1:0] count_q;
	logic                      drop_q;
	logic                      full;

	assign full     = (count_q == tsd_pkg::FULL_CNT);
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_rec.term  = tsd_pkg::term_t'(s_tdata[tsd_pkg::TERM_W-1:0]);
		push_rec.store = !full;
		push_rec.last  = s_tlast;
		push_rec.drop  = drop_q || full;
		push_rec.cnt   = full ? count_q : count_q + tsd_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (push) begin
			if (s_tlast) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + tsd_pkg::CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/tsd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_fifo: short record queue between front and back end
// A few entries of classified items, so each side can stall on its own.
// ----------------------------------------------------------------------------
module tsd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tsd_pkg::rec_t push_rec,
	input  wire logic          pop,
	output tsd_pkg::rec_t      pop_rec,
	output tsd_pkg::q_stat_t   q_stat
);

	tsd_pkg::rec_t               mem_q [tsd_pkg::Q_DEPTH];
	logic [tsd_pkg::Q_PTR_W-1:0] wptr_q;
	logic [tsd_pkg::Q_PTR_W-1:0] rptr_q;
	logic [tsd_pkg::Q_CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == tsd_pkg::Q_CNT_W'(tsd_pkg::Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_rec      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + tsd_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + tsd_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + tsd_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - tsd_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/tsd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_back: term store, interchange sort and result output
// Writes queued terms into the store RAM, sorts a finished run in place and
// streams it out through an output register.
// ----------------------------------------------------------------------------
module tsd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tsd_pkg::q_stat_t            q_stat,
	input  wire tsd_pkg::rec_t               pop_rec,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [tsd_pkg::TDATA_W-1:0] m_tdata,
	output logic                             m_tlast,
	output logic                             m_tuser
);

	tsd_pkg::back_state_t state_q, state_nx;

	logic [tsd_pkg::IDX_W-1:0] i_q, j_q, k_q;
	logic [tsd_pkg::IDX_W-1:0] i_nx, j_nx, k_nx, last_idx;
	logic [tsd_pkg::CNT_W-1:0] n_q;
	logic                      drop_q;
	tsd_pkg::term_t            hold_q;

	logic                      ram_we, ram_re;
	logic [tsd_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
	tsd_pkg::term_t            ram_wdata;
	logic [tsd_pkg::TERM_W-1:0] ram_rdata;
	tsd_pkg::term_t            rd_term;

	logic                      out_valid_q, out_last_q, out_drop_q;
	tsd_pkg::term_t            out_term_q;
	logic                      out_free, ld_out, swap, run_start;

	tsd_ram #(
		.WIDTH (tsd_pkg::TERM_W),
		.DEPTH (tsd_pkg::MAX_TERMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_term   = tsd_pkg::term_t'(ram_rdata);
	assign i_nx      = i_q + tsd_pkg::IDX_W'(1);
	assign j_nx      = j_q + tsd_pkg::IDX_W'(1);
	assign k_nx      = k_q + tsd_pkg::IDX_W'(1);
	assign last_idx  = tsd_pkg::IDX_W'(n_q - tsd_pkg::CNT_W'(1));
	assign out_free  = !out_valid_q || m_tready;
	assign swap      = hold_q.deg > rd_term.deg;
	assign run_start = (state_q == tsd_pkg::ST_FILL) && !q_stat.empty && pop_rec.last;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tsd_pkg::ST_FILL: begin
				if (!q_stat.empty && pop_rec.last) begin
					state_nx = (pop_rec.cnt == tsd_pkg::CNT_W'(1)) ?
						tsd_pkg::ST_ERD : tsd_pkg::ST_RD_I;
				end
			end
			tsd_pkg::ST_RD_I: state_nx = tsd_pkg::ST_LD_I;
			tsd_pkg::ST_LD_I: state_nx = tsd_pkg::ST_CMP;
			tsd_pkg::ST_CMP: begin
				if (j_q == last_idx) begin
					state_nx = tsd_pkg::ST_WB;
				end
			end
			tsd_pkg::ST_WB: begin
				state_nx = (i_nx == last_idx) ? tsd_pkg::ST_ERD : tsd_pkg::ST_LD_I;
			end
			tsd_pkg::ST_ERD: state_nx = tsd_pkg::ST_EOUT;
			tsd_pkg::ST_EOUT: begin
				if (out_free) begin
					state_nx = (k_q == last_idx) ? tsd_pkg::ST_FILL : tsd_pkg::ST_ERD;
				end
			end
			default: state_nx = tsd_pkg::ST_FILL;
		endcase
	end

	// RAM port control, queue pop and output load.
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = hold_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ld_out    = 1'b0;
		unique case (state_q)
			tsd_pkg::ST_FILL: begin
				pop       = !q_stat.empty;
				ram_we    = !q_stat.empty && pop_rec.store;
				ram_waddr = tsd_pkg::IDX_W'(pop_rec.cnt - tsd_pkg::CNT_W'(1));
				ram_wdata = pop_rec.term;
			end
			tsd_pkg::ST_RD_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			tsd_pkg::ST_LD_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_nx;
			end
			tsd_pkg::ST_CMP: begin
				ram_we    = swap;
				ram_waddr = j_q;
				ram_re    = (j_q != last_idx);
				ram_raddr = j_nx;
			end
			tsd_pkg::ST_WB: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_re    = (i_nx != last_idx);
				ram_raddr = i_nx;
			end
			tsd_pkg::ST_ERD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
			end
			tsd_pkg::ST_EOUT: begin
				ld_out = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsd_pkg::ST_FILL;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (run_start) begin
				n_q    <= pop_rec.cnt;
				drop_q <= pop_rec.drop;
				i_q    <= '0;
				k_q    <= '0;
			end
			if (state_q == tsd_pkg::ST_LD_I) begin
				j_q <= i_nx;
			end
			if (state_q == tsd_pkg::ST_CMP) begin
				j_q <= j_nx;
			end
			if (state_q == tsd_pkg::ST_WB) begin
				i_q <= i_nx;
			end
			if (ld_out && (k_q != last_idx)) begin
				k_q <= k_nx;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == tsd_pkg::ST_LD_I || (state_q == tsd_pkg::ST_CMP && swap)) begin
			hold_q <= rd_term;
		end
		if (ld_out) begin
			out_term_q <= rd_term;
			out_last_q <= (k_q == last_idx);
			out_drop_q <= drop_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tsd_pkg::TDATA_W'(out_term_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

endmodule
`default_nettype wire

// File: src/tsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_checker: port-level checks of the term sorter
// Watches both streams and checks run bookkeeping, ordering and flags.
// ----------------------------------------------------------------------------
module tsd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic                        s_tlast,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [tsd_pkg::TDATA_W-1:0] m_tdata,
	input wire logic                        m_tlast,
	input wire logic                        m_tuser
);

	logic                      in_last_acc, out_acc;
	logic [3:0]                pending_q;
	logic                      mid_run_q;
	logic [tsd_pkg::DEG_W-1:0] prev_deg_q;
	logic                      prev_user_q;

	assign in_last_acc = s_tvalid && s_tready && s_tlast;
	assign out_acc     = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			mid_run_q <= 1'b0;
		end else begin
			if (in_last_acc && !(out_acc && m_tlast)) begin
				pending_q <= pending_q + 4'd1;
			end else if (!in_last_acc && out_acc && m_tlast) begin
				pending_q <= pending_q - 4'd1;
			end
			if (out_acc) begin
				mid_run_q <= !m_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_deg_q  <= m_tdata[tsd_pkg::COEF_W +: tsd_pkg::DEG_W];
			prev_user_q <= m_tuser;
		end
	end

	// A result shows only once its polynomial's last term was taken in.
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pending_q != 4'd0))
		else $error("result shown with no finished polynomial pending");

	// Degrees within one polynomial leave in ascending order.
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && mid_run_q) |->
			(m_tdata[tsd_pkg::COEF_W +: tsd_pkg::DEG_W] >= prev_deg_q))
		else $error("sorted degrees out of order");

	// The overflow flag is the same on every result of a polynomial.
	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && mid_run_q) |-> (m_tuser == prev_user_q))
		else $error("overflow flag changed inside a polynomial");

	// A stalled result stays put.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
			(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind term_sort_by_degree tsd_checker u_tsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
